>>> rtl/lstp_pkg.sv
package lstp_pkg;

  localparam int SCAN_POINTS      = 1080;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;

  localparam int IDX_W      = 11;
  localparam int RANGE_W    = 16;
  localparam int COORD_W    = 17;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 40;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int XY_W  = 36;
  localparam int Z_W   = 34;
  localparam int ANG_W = 32;

  localparam logic [RANGE_W-1:0] NO_RETURN = 16'hFFFF;
  localparam logic [29:0]        KINV_Q30  = 30'd652032874;
  localparam int                 OUT_MAX   = 65535;

  // quarter degrees in a turn, and the split of a count into groups of 45
  localparam int QDEG_TURN = 1440;
  localparam int GRP       = 45;
  localparam logic [10:0] RECIP_GRP = 11'd1457;

  localparam logic [RANGE_W-1:0] GATE_RST  = 16'd5500;
  localparam logic [IDX_W-1:0]   WFIRST_RST = 11'd380;
  localparam logic [IDX_W-1:0]   WLAST_RST  = 11'd699;
  localparam logic [IDX_W-1:0]   ZERO_RST   = 11'd180;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_LIMIT   = 4'd0,
    REG_WINDOW_FIRST = 4'd1,
    REG_WINDOW_LAST  = 4'd2,
    REG_ANGLE_ZERO   = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RANGE_W-1:0] gate_limit;
    logic [IDX_W-1:0]   window_first;
    logic [IDX_W-1:0]   window_last;
    logic [IDX_W-1:0]   angle_zero;
  } cfg_t;

  typedef struct packed {
    logic                   keep;
    logic                   last;
    logic                   flip;
    logic signed [XY_W-1:0] cx;
    logic signed [XY_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef logic [ANG_W-1:0] atan_tab_t [MAX_STEPS];

  // atan(2^-i) as a binary angle, one turn = 2^32
  localparam atan_tab_t ATAN_TAB = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic [26:0] frac_tab_t [GRP];

  // round(b * 2^27 / 45), the binary angle of b quarter degrees
  function automatic frac_tab_t make_frac_tab();
    frac_tab_t t;
    for (int b = 0; b < GRP; b++) begin
      t[b] = 27'((((longint'(b)) << 28) / GRP + 1) >> 1);
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = make_frac_tab();

endpackage

>>> rtl/lstp_front.sv
module lstp_front
  import lstp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic [IDX_W-1:0]   sample_index,
  input  logic [RANGE_W-1:0] range_mm,
  input  logic               scan_end,
  output logic               out_valid,
  output cordic_t            out
);

  // stage 1: gating, angle wrap, start vector
  logic        v1, keep1, last1;
  logic [10:0] q1;
  logic [31:0] cx1;
  // stage 2: group count
  logic        v2, keep2, last2;
  logic [10:0] q2;
  logic [4:0]  a2;
  logic [31:0] cx2;
  // stage 3: remainder
  logic        v3, keep3, last3;
  logic [4:0]  a3;
  logic [5:0]  b3;
  logic [31:0] cx3;

  logic        keep_c;
  logic [12:0] d0, d1, d2;
  logic [45:0] prod;
  logic [21:0] a_prod;
  logic [10:0] grp_mul;
  logic [ANG_W-1:0] ang, ang_f, ang_chk;

  always_comb begin
    keep_c = (sample_index >= cfg.window_first) && (sample_index <= cfg.window_last) &&
             ({2'b00, sample_index} < 13'(SCAN_POINTS)) &&
             (range_mm != NO_RETURN) && (range_mm < cfg.gate_limit);
    d0 = 13'(sample_index) + 13'(2 * QDEG_TURN) - 13'(cfg.angle_zero);
    d1 = (d0 >= 13'(2 * QDEG_TURN)) ? d0 - 13'(2 * QDEG_TURN) : d0;
    d2 = (d1 >= 13'(QDEG_TURN)) ? d1 - 13'(QDEG_TURN) : d1;
    prod = 46'(range_mm) * 46'(KINV_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      keep1 <= keep_c;
      last1 <= scan_end;
      q1    <= d2[10:0];
      cx1   <= prod[45:14];
    end
  end

  // q / 45 by reciprocal, exact for q below one turn
  assign a_prod = 22'(q1) * 22'(RECIP_GRP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      keep2 <= keep1;
      last2 <= last1;
      q2    <= q1;
      a2    <= a_prod[20:16];
      cx2   <= cx1;
    end
  end

  assign grp_mul = 11'(a2) * 11'(GRP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      keep3 <= keep2;
      last3 <= last2;
      a3    <= a2;
      b3    <= 6'(q2 - grp_mul);
      cx3   <= cx2;
    end
  end

  // binary angle, folded into [-90, 90) degrees
  always_comb begin
    ang     = {a3, FRAC_TAB[b3]};
    ang_chk = ang + 32'h4000_0000;
    ang_f   = ang_chk[31] ? ang + 32'h8000_0000 : ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
    if (adv) begin
      out.keep <= keep3;
      out.last <= last3;
      out.flip <= ang_chk[31];
      out.cx   <= $signed({4'b0000, cx3});
      out.cy   <= '0;
      out.z    <= Z_W'($signed(ang_f));
    end
  end

endmodule

>>> rtl/lstp_cordic_step.sv
module lstp_cordic_step
  import lstp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  cordic_t in,
  output logic    out_valid,
  output cordic_t out
);

  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;

  assign dx = $signed(in.cy) >>> STEP;
  assign dy = $signed(in.cx) >>> STEP;
  assign da = Z_W'($signed({1'b0, ATAN_TAB[STEP]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out.keep <= in.keep;
      out.last <= in.last;
      out.flip <= in.flip;
      if (!in.z[Z_W-1]) begin
        out.cx <= in.cx - dx;
        out.cy <= in.cy + dy;
        out.z  <= in.z - da;
      end else begin
        out.cx <= in.cx + dx;
        out.cy <= in.cy - dy;
        out.z  <= in.z + da;
      end
    end
  end

endmodule

>>> rtl/lstp_back.sv
module lstp_back
  import lstp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  cordic_t                   in,
  output logic                      out_valid,
  output logic                      point_valid,
  output logic signed [COORD_W-1:0] x_mm,
  output logic signed [COORD_W-1:0] y_mm,
  output logic                      scan_end_out
);

  logic                   v1, keep1, last1;
  logic signed [XY_W-1:0] xpre, ypre;

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + XY_W'(32768)) >>> 16;
    if (r > XY_W'(OUT_MAX)) begin
      return COORD_W'(OUT_MAX);
    end else if (r < -XY_W'(OUT_MAX)) begin
      return -COORD_W'(OUT_MAX);
    end
    return COORD_W'(r);
  endfunction

  // undo the half-turn fold and map to x forward, y left
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      keep1 <= in.keep;
      last1 <= in.last;
      xpre  <= in.flip ? -in.cy : in.cy;
      ypre  <= in.flip ? in.cx : -in.cx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
    if (adv) begin
      point_valid  <= keep1;
      scan_end_out <= last1;
      x_mm         <= keep1 ? round_sat(xpre) : '0;
      y_mm         <= keep1 ? round_sat(ypre) : '0;
    end
  end

endmodule

>>> rtl/lidar_scan_to_points.sv
// Lidar scan to planar points. Each accepted sample (beam index, range in
// millimetres) gives exactly one result: point_valid in tuser, x and y in
// millimetres in tdata, and the end-of-scan mark on tlast. A sample is kept
// when its index lies in [window_first, window_last] and below 1080, its range
// is below gate_limit_mm and is not the no-return code; else x and y are zero.
// The beam angle is (index - angle_zero_index) quarter degrees, and the point
// is x = sin(angle)*range, y = -cos(angle)*range, rounded to the millimetre
// and clamped to +-65535. One sample is taken every clock unless the output
// stalls. The pipeline has four front stages (gating, group count, remainder,
// angle table and fold), one stage per CORDIC iteration and two output stages.
// The whole pipeline moves together and holds while the result is not taken.
// Configuration writes are always accepted and take effect at once.
module lidar_scan_to_points
  import lstp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,  // sample_index, range_mm
  input  logic                  s_tlast,  // scan_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,  // x_mm, y_mm
  output logic                  m_tuser,  // point_valid
  output logic                  m_tlast,  // scan_end_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic adv;

  cordic_t                    st [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]      vst;
  logic signed [COORD_W-1:0]  x_mm, y_mm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_limit   <= GATE_RST;
      cfg.window_first <= WFIRST_RST;
      cfg.window_last  <= WLAST_RST;
      cfg.angle_zero   <= ZERO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GATE_LIMIT:   cfg.gate_limit   <= cfg_data;
        REG_WINDOW_FIRST: cfg.window_first <= cfg_data[IDX_W-1:0];
        REG_WINDOW_LAST:  cfg.window_last  <= cfg_data[IDX_W-1:0];
        REG_ANGLE_ZERO:   cfg.angle_zero   <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // every stage advances while the output register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  lstp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .sample_index (s_tdata[IDX_W-1:0]),
    .range_mm     (s_tdata[IDX_W+RANGE_W-1:IDX_W]),
    .scan_end     (s_tlast),
    .out_valid    (vst[0]),
    .out          (st[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    lstp_cordic_step #(
      .STEP (i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (vst[i]),
      .in        (st[i]),
      .out_valid (vst[i+1]),
      .out       (st[i+1])
    );
  end

  lstp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (vst[CORDIC_STEPS]),
    .in           (st[CORDIC_STEPS]),
    .out_valid    (m_tvalid),
    .point_valid  (m_tuser),
    .x_mm         (x_mm),
    .y_mm         (y_mm),
    .scan_end_out (m_tlast)
  );

  assign m_tdata = {6'b000000, y_mm, x_mm};

  // a dropped sample carries no coordinates
  a_zero_when_dropped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[2*COORD_W-1:0] == '0)
    else $error("dropped sample with non-zero coordinates");

  // clamp never lets the most negative code through
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (x_mm != -COORD_W'(OUT_MAX + 1)) && (y_mm != -COORD_W'(OUT_MAX + 1)))
    else $error("coordinate beyond clamp");

  a_gate_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_GATE_LIMIT |=> cfg.gate_limit == $past(cfg_data))
    else $error("gate limit write lost");

  // an output register that is held must keep its transaction
  a_hold_under_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

>>> tb/lstp_point_checker.sv
`timescale 1ns / 1ps

module lstp_point_checker
  import lstp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_W-1:0]      m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    points_owed
);

  localparam int     ROT_STEPS   = 16;
  localparam longint QDEG_PER_REV = 1440;
  localparam longint MAX_BEAMS   = 1080;
  localparam longint GAIN_INV    = 652032874;
  localparam longint COORD_LIMIT = 65535;

  // atan(2^-i) as a binary angle, one turn = 2^32
  localparam longint ATAN_BAM [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } point_t;

  cfg_t   settings;
  point_t expected_points [$];
  point_t got;
  point_t want;

  function automatic logic signed [COORD_W-1:0] round_mm(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > COORD_LIMIT) r = COORD_LIMIT;
    if (r < -COORD_LIMIT) r = -COORD_LIMIT;
    return r[COORD_W-1:0];
  endfunction

  function automatic point_t project_sample(logic [IDX_W-1:0] idx,
                                            logic [RANGE_W-1:0] rng, logic last);
    point_t      p;
    longint      q;
    longint      bam;
    logic [31:0] ang;
    logic [31:0] probe;
    logic        flip;
    longint      z;
    longint      cx;
    longint      cy;
    longint      dx;
    longint      dy;
    p = '0;
    p.last = last;
    p.valid = idx >= settings.window_first && idx <= settings.window_last &&
              longint'(idx) < MAX_BEAMS && rng != 16'hFFFF && rng < settings.gate_limit;
    if (p.valid) begin
      q = (longint'(idx) + 2 * QDEG_PER_REV - longint'(settings.angle_zero)) % QDEG_PER_REV;
      bam = (q * 64'h1_0000_0000 + 720) / QDEG_PER_REV;
      ang = bam[31:0];
      probe = ang + 32'h4000_0000;
      flip = probe[31];
      // outside [-90, 90) degrees: rotate by half a turn and negate afterwards
      if (flip) ang = ang + 32'h8000_0000;
      z = longint'($signed(ang));
      cx = (longint'(rng) * GAIN_INV) >>> 14;
      cy = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ATAN_BAM[i];
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ATAN_BAM[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      p.x = round_mm(cy);
      p.y = round_mm(-cx);
    end
    return p;
  endfunction

  task automatic flag_point(string what, point_t exp_p, point_t act_p);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected valid=%0b x=%0d y=%0d last=%0b,",
               $time, what, exp_p.valid, exp_p.x, exp_p.y, exp_p.last,
               " got valid=%0b x=%0d y=%0d last=%0b",
               act_p.valid, act_p.x, act_p.y, act_p.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings.gate_limit   = GATE_RST;
      settings.window_first = WFIRST_RST;
      settings.window_last  = WLAST_RST;
      settings.angle_zero   = ZERO_RST;
      expected_points.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.valid = m_tuser;
        got.x     = m_tdata[COORD_W-1:0];
        got.y     = m_tdata[2*COORD_W-1:COORD_W];
        got.last  = m_tlast;
        if (expected_points.size() == 0) begin
          flag_point("point with nothing outstanding", '0, got);
        end else begin
          want = expected_points.pop_front();
          if (got != want) flag_point("point mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GATE_LIMIT:   settings.gate_limit   = cfg_data;
          REG_WINDOW_FIRST: settings.window_first = cfg_data[IDX_W-1:0];
          REG_WINDOW_LAST:  settings.window_last  = cfg_data[IDX_W-1:0];
          REG_ANGLE_ZERO:   settings.angle_zero   = cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_points.insert(expected_points.size(),
                               project_sample(s_tdata[IDX_W-1:0],
                                              s_tdata[IDX_W+RANGE_W-1:IDX_W], s_tlast));
      end
    end
    points_owed = expected_points.size();
  end

endmodule

>>> tb/tb_lidar_scan_to_points.sv
`timescale 1ns / 1ps

module tb_lidar_scan_to_points;
  import lstp_pkg::*;

  localparam int PIPE_DEPTH  = CORDIC_STEPS_DEF + 6;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int points_owed;
  int cycles;
  bit calm;

  lidar_scan_to_points dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lstp_point_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .points_owed (points_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99, 0) >= 28);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // each task is entered and left at a falling edge
  task automatic send_sample(input int idx, input int rng, input bit last);
    while (!calm && $urandom_range(99, 0) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, rng[RANGE_W-1:0], idx[IDX_W-1:0]};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (points_owed != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic load_settings(input int gate, input int first, input int lst, input int zero,
                               input int junk);
    drain_pipe();
    write_reg(REG_GATE_LIMIT, gate);
    write_reg(REG_WINDOW_FIRST, first);
    write_reg(REG_WINDOW_LAST, lst);
    write_reg(REG_ANGLE_ZERO, zero);
    // unmapped register index, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(15, 4)), junk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int gate;
    int first;
    int lst;
    int zero;
    int idx;
    int rng;
    bit last;
    calm      = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // settings straight out of reset: window edges, gate edge, no return, 90 degrees
    send_sample(380, 0, 0);
    send_sample(699, 5499, 0);
    send_sample(379, 100, 0);
    send_sample(700, 100, 0);
    send_sample(500, 5500, 0);
    send_sample(500, 65535, 0);
    send_sample(540, 1000, 1);

    // widest window, largest gate: every quadrant at full range, indices past the scan
    load_settings(65535, 0, 2047, 0, 16'hFFFF);
    send_sample(0, 65534, 0);
    send_sample(360, 65534, 0);
    send_sample(720, 65534, 0);
    send_sample(1079, 65534, 0);
    send_sample(1080, 100, 0);
    send_sample(2047, 65534, 0);
    send_sample(1079, 0, 0);
    send_sample(100, 65535, 0);
    send_sample(900, 65534, 1);

    // empty window and zero gate
    load_settings(0, 2047, 0, 2047, 16'h0000);
    send_sample(0, 0, 0);
    send_sample(2047, 65535, 0);
    send_sample(1000, 12345, 1);

    // single-index window at the top of the scan, gate of one
    load_settings(1, 1079, 1079, 1079, 16'hA5A5);
    send_sample(1079, 0, 0);
    send_sample(1079, 1, 0);
    send_sample(1078, 0, 0);
    send_sample(1079, 0, 1);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(5, 0))
        0:       gate = 0;
        1:       gate = 65535;
        2:       gate = 5500;
        default: gate = $urandom_range(65535, 1);
      endcase
      case ($urandom_range(3, 0))
        0: begin
          first = 0;
          lst   = 2047;
        end
        1: begin
          first = $urandom_range(1079, 0);
          lst   = $urandom_range(1079, first);
        end
        2: begin
          first = $urandom_range(2047, 0);
          lst   = $urandom_range(2047, 0);
        end
        default: begin
          first = $urandom_range(1079, 0);
          lst   = first;
        end
      endcase
      zero = ($urandom_range(3, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(1079, 0);
      // window registers ignore the upper data bits
      if ($urandom_range(1, 0) == 1) begin
        first = first | ($urandom_range(31, 0) << IDX_W);
        lst   = lst | ($urandom_range(31, 0) << IDX_W);
      end
      load_settings(gate, first, lst, zero, $urandom_range(65535, 0));
      first = first % 2048;
      lst   = lst % 2048;
      calm  = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        if (first <= lst && gate > 0 && $urandom_range(99, 0) < 80) begin
          idx  = $urandom_range(lst, first);
          rng  = ($urandom_range(9, 0) == 0) ? gate - 1 : $urandom_range(gate - 1, 0);
          last = (idx == lst) || ($urandom_range(31, 0) == 0);
        end else begin
          idx  = $urandom_range(2047, 0);
          rng  = ($urandom_range(3, 0) == 0) ? 65535 : $urandom_range(65535, 0);
          last = $urandom_range(1, 0);
        end
        send_sample(idx, rng, last);
      end
      calm = 1'b0;
    end

    drain_pipe();
    if (mismatches == 0 && points_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lstp_pkg.sv
rtl/lstp_front.sv
rtl/lstp_cordic_step.sv
rtl/lstp_back.sv
rtl/lidar_scan_to_points.sv
tb/lstp_point_checker.sv
tb/tb_lidar_scan_to_points.sv
